// ===== rtl/core/http_request_classifier_macros.svh =====
// ----------------------------------------------------------------------------
// http_request_classifier_macros.svh
// assertion macros used by the checker file of the classifier
// ----------------------------------------------------------------------------
`ifndef HTTP_REQUEST_CLASSIFIER_MACROS_SVH
`define HTTP_REQUEST_CLASSIFIER_MACROS_SVH

// plain clocked property, switched off while reset is low
`define HRC_ASSERT(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) \
    else $error("classifier assertion failed");

// a signal holds while its channel is valid and stalled
`define HRC_ASSERT_HELD(lbl, clk, rstn, vld, rdy, sig) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) \
    ((vld) && !(rdy) |=> $stable(sig))) \
    else $error("classifier signal changed while stalled");

`endif

// ===== rtl/core/hrc_pkg.sv =====
// ----------------------------------------------------------------------------
// hrc_pkg
// shared types, response codes and match strings of the request classifier
// ----------------------------------------------------------------------------
package hrc_pkg;

  // bytes held without the blank line that ends a request before the block gives up
  localparam int unsigned BUFFER_BYTES = 8192;
  localparam int unsigned PendW        = $clog2(BUFFER_BYTES + 1);

  // response kinds
  localparam logic [2:0] KIND_HEALTH     = 3'd0;
  localparam logic [2:0] KIND_PLAINTEXT  = 3'd1;
  localparam logic [2:0] KIND_NOT_FOUND  = 3'd2;
  localparam logic [2:0] KIND_BAD_METHOD = 3'd3;
  localparam logic [2:0] KIND_BAD_REQ    = 3'd4;
  localparam logic [2:0] KIND_TOO_LARGE  = 3'd5;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef struct packed {
    logic [2:0] response_kind;
    logic       close_after;
  } result_t;

  // "GET "
  function automatic logic [7:0] get_char(logic [1:0] i);
    logic [7:0] c;
    case (i)
      2'd0:    c = 8'h47;
      2'd1:    c = 8'h45;
      2'd2:    c = 8'h54;
      default: c = 8'h20;
    endcase
    return c;
  endfunction

  // "/health"
  function automatic logic [7:0] health_char(logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0:    c = 8'h2f;
      3'd1:    c = 8'h68;
      3'd2:    c = 8'h65;
      3'd3:    c = 8'h61;
      3'd4:    c = 8'h6c;
      3'd5:    c = 8'h74;
      3'd6:    c = 8'h68;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "/plaintext"
  function automatic logic [7:0] plain_char(logic [3:0] i);
    logic [7:0] c;
    case (i)
      4'd0:    c = 8'h2f;
      4'd1:    c = 8'h70;
      4'd2:    c = 8'h6c;
      4'd3:    c = 8'h61;
      4'd4:    c = 8'h69;
      4'd5:    c = 8'h6e;
      4'd6:    c = 8'h74;
      4'd7:    c = 8'h65;
      4'd8:    c = 8'h78;
      4'd9:    c = 8'h74;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // " HTTP/1.1"
  function automatic logic [7:0] version_char(logic [3:0] i);
    logic [7:0] c;
    case (i)
      4'd0:    c = 8'h20;
      4'd1:    c = 8'h48;
      4'd2:    c = 8'h54;
      4'd3:    c = 8'h54;
      4'd4:    c = 8'h50;
      4'd5:    c = 8'h2f;
      4'd6:    c = 8'h31;
      4'd7:    c = 8'h2e;
      4'd8:    c = 8'h31;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "connection:"
  function automatic logic [7:0] name_char(logic [3:0] i);
    logic [7:0] c;
    case (i)
      4'd0:    c = 8'h63;
      4'd1:    c = 8'h6f;
      4'd2:    c = 8'h6e;
      4'd3:    c = 8'h6e;
      4'd4:    c = 8'h65;
      4'd5:    c = 8'h63;
      4'd6:    c = 8'h74;
      4'd7:    c = 8'h69;
      4'd8:    c = 8'h6f;
      4'd9:    c = 8'h6e;
      4'd10:   c = 8'h3a;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

  // "close", first letter either case handled by the caller
  function automatic logic [7:0] word_char(logic [2:0] i);
    logic [7:0] c;
    case (i)
      3'd0:    c = 8'h63;
      3'd1:    c = 8'h6c;
      3'd2:    c = 8'h6f;
      3'd3:    c = 8'h73;
      3'd4:    c = 8'h65;
      default: c = 8'h00;
    endcase
    return c;
  endfunction

endpackage

// ===== rtl/core/hrc_if.sv =====
// ----------------------------------------------------------------------------
// hrc_if
// valid/ready channels for received bytes and classified responses
// ----------------------------------------------------------------------------
interface hrc_req_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       new_connection;

  modport source (output valid, output data_byte, output new_connection, input ready);
  modport sink   (input valid, input data_byte, input new_connection, output ready);
endinterface

interface hrc_rsp_if;
  logic       valid;
  logic       ready;
  logic [2:0] response_kind;
  logic       close_after;

  modport source (output valid, output response_kind, output close_after, input ready);
  modport sink   (input valid, input response_kind, input close_after, output ready);
endinterface

// ===== rtl/core/hrc_parser.sv =====
// ----------------------------------------------------------------------------
// hrc_parser
// running match state of one connection, advanced by one byte per step
// ----------------------------------------------------------------------------
module hrc_parser (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                step_i,
  input  logic [7:0]          data_byte_i,
  input  logic                new_connection_i,
  output logic                res_valid_o,
  output hrc_pkg::result_t    res_o
);

  localparam logic [1:0] PH_REQ  = 2'd0;
  localparam logic [1:0] PH_HDR  = 2'd1;
  localparam logic [1:0] PH_VAL  = 2'd2;
  localparam logic [1:0] PH_SKIP = 2'd3;
  localparam logic [3:0] PROG_FAIL = 4'd15;

  typedef struct packed {
    logic                       closed;
    logic                       close_req;
    logic [2:0]                 cprog;
    logic [3:0]                 hprog;
    logic [3:0]                 vprog;
    logic [1:0]                 tmatch;
    logic                       method_ok;
    logic [3:0]                 lpos;      // saturates, only small values matter
    logic [1:0]                 phase;
    logic [1:0]                 tprog;
    logic [hrc_pkg::PendW-1:0]  pending;
  } pst_t;

  localparam pst_t ST_INIT = '{
    closed: 1'b0, close_req: 1'b0, cprog: 3'd0, hprog: 4'd0, vprog: 4'd0,
    tmatch: 2'b11, method_ok: 1'b0, lpos: 4'd0, phase: PH_REQ, tprog: 2'd0,
    pending: '0
  };

  function automatic logic [7:0] to_lower(logic [7:0] b);
    logic [7:0] r;
    r = b;
    if (b >= 8'h41 && b <= 8'h5a) r = b + 8'd32;
    return r;
  endfunction

  function automatic pst_t feed(pst_t s, logic [7:0] b);
    pst_t       r;
    logic [3:0] t;
    logic       m;
    logic       first;
    r = s;
    t = s.lpos - 4'd4;
    m = 1'b0;
    first = 1'b0;
    case (s.phase)
      PH_REQ: begin
        if (s.lpos < 4'd4) begin
          m = (b == hrc_pkg::get_char(s.lpos[1:0]));
          r.method_ok = (s.lpos == 4'd0) ? m : (s.method_ok && m);
        end else if (s.vprog == 4'd0) begin
          if (b == hrc_pkg::CH_SPACE) begin
            r.tmatch[0] = s.tmatch[0] && (t == 4'd7);
            r.tmatch[1] = s.tmatch[1] && (t == 4'd10);
            r.vprog     = 4'd1;
          end else begin
            if (!(t < 4'd7 && b == hrc_pkg::health_char(t[2:0]))) r.tmatch[0] = 1'b0;
            if (!(t < 4'd10 && b == hrc_pkg::plain_char(t))) r.tmatch[1] = 1'b0;
          end
        end else if (s.vprog < 4'd9) begin
          if (b == hrc_pkg::version_char(s.vprog)) r.vprog = s.vprog + 4'd1;
          else r.vprog = PROG_FAIL;
        end
        if (s.lpos != 4'd15) r.lpos = s.lpos + 4'd1;
      end
      PH_HDR: begin
        if (s.hprog < 4'd11) begin
          if (to_lower(b) == hrc_pkg::name_char(s.hprog)) begin
            r.hprog = s.hprog + 4'd1;
            if (s.hprog == 4'd10) begin
              r.phase = PH_VAL;
              r.cprog = 3'd0;
            end
          end else begin
            r.hprog = PROG_FAIL;
          end
        end
      end
      PH_VAL: begin
        if (s.cprog < 3'd5) begin
          first = (b == 8'h63) || (b == 8'h43);
          m = (s.cprog == 3'd0) ? first : (b == hrc_pkg::word_char(s.cprog));
          if (m) r.cprog = s.cprog + 3'd1;
          else r.cprog = first ? 3'd1 : 3'd0;
          if (m && s.cprog == 3'd4) r.close_req = 1'b1;
        end
      end
      default: begin
        // remaining header lines are skipped
      end
    endcase
    return r;
  endfunction

  function automatic pst_t end_line(pst_t s);
    pst_t r;
    r = s;
    if (s.phase == PH_VAL) r.phase = PH_SKIP;
    else if (s.phase != PH_SKIP) r.phase = PH_HDR;
    r.hprog = 4'd0;
    return r;
  endfunction

  pst_t             st_q, st_d;
  pst_t             cur, nxt;
  logic             prev_cr;
  logic             res_valid;
  hrc_pkg::result_t res;

  always_comb begin
    cur       = new_connection_i ? ST_INIT : st_q;
    nxt       = cur;
    res_valid = 1'b0;
    res       = '{response_kind: hrc_pkg::KIND_HEALTH, close_after: 1'b0};
    prev_cr   = (cur.tprog == 2'd1) || (cur.tprog == 2'd3);
    if (!cur.closed) begin
      if (data_byte_i == hrc_pkg::CH_LF && prev_cr && cur.tprog == 2'd3) begin
        // end of request
        res_valid = 1'b1;
        if (cur.lpos < 4'd4 || !cur.method_ok) begin
          res = '{response_kind: hrc_pkg::KIND_BAD_METHOD, close_after: 1'b1};
        end else if (cur.vprog != 4'd9) begin
          res = '{response_kind: hrc_pkg::KIND_BAD_REQ, close_after: 1'b1};
        end else begin
          res.close_after = cur.close_req;
          if (cur.tmatch[0]) res.response_kind = hrc_pkg::KIND_HEALTH;
          else if (cur.tmatch[1]) res.response_kind = hrc_pkg::KIND_PLAINTEXT;
          else res.response_kind = hrc_pkg::KIND_NOT_FOUND;
        end
        nxt        = ST_INIT;
        nxt.closed = res.close_after;
      end else begin
        if (data_byte_i == hrc_pkg::CH_LF && prev_cr) begin
          nxt       = end_line(cur);
          nxt.tprog = 2'd2;
        end else begin
          // a held cr that was not followed by lf belongs to the line
          if (prev_cr) nxt = feed(nxt, hrc_pkg::CH_CR);
          if (data_byte_i == hrc_pkg::CH_CR) begin
            nxt.tprog = (cur.tprog == 2'd2) ? 2'd3 : 2'd1;
          end else begin
            nxt       = feed(nxt, data_byte_i);
            nxt.tprog = 2'd0;
          end
        end
        nxt.pending = cur.pending + 1'b1;
        if (nxt.pending >= hrc_pkg::PendW'(hrc_pkg::BUFFER_BYTES)) begin
          nxt.closed = 1'b1;
          res_valid  = 1'b1;
          res        = '{response_kind: hrc_pkg::KIND_TOO_LARGE, close_after: 1'b1};
        end
      end
    end
    st_d = step_i ? nxt : st_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_INIT;
    end else begin
      st_q <= st_d;
    end
  end

  assign res_valid_o = step_i && res_valid;
  assign res_o       = res;

endmodule

// ===== rtl/core/http_request_classifier.sv =====
// path: an accepted byte waits in the input register, and its result is then held in the result register
// throughput: one byte per cycle while the result register is not stalled; the parse state is updated once per byte
// a stalled result register holds one result while the input register takes the next byte
// reset: asynchronous, active low; clears both registers' valid flags and all parse state,
// which starts as a fresh connection at the request line
// ----------------------------------------------------------------------------
// http_request_classifier
// classifies http/1.1 requests on a connection byte stream, one byte per word
// ----------------------------------------------------------------------------
module http_request_classifier (
  input  logic             clk_i,
  input  logic             rst_ni,
  hrc_req_if.sink          req_i,
  hrc_rsp_if.source        rsp_o
);

  // input register: one received word
  logic             in_vld_q;
  logic [7:0]       in_byte_q;
  logic             in_new_q;

  // result register
  logic             out_vld_q;
  hrc_pkg::result_t out_q;

  // parser outputs
  logic             res_valid;
  hrc_pkg::result_t res;

  // the held word is consumed when the result register is free or being drained
  logic             step;

  assign step        = in_vld_q && (!out_vld_q || rsp_o.ready);
  assign req_i.ready = !in_vld_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      if (req_i.valid && req_i.ready) begin
        in_vld_q <= 1'b1;
      end else if (step) begin
        in_vld_q <= 1'b0;
      end
    end
  end

  // payload of the input register, no reset needed
  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      in_byte_q <= req_i.data_byte;
      in_new_q  <= req_i.new_connection;
    end
  end

  // parse state and the decision for the held word
  hrc_parser u_parser (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .step_i           (step),
    .data_byte_i      (in_byte_q),
    .new_connection_i (in_new_q),
    .res_valid_o      (res_valid),
    .res_o            (res)
  );

  // most words give no result; the register empties once its result is taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      if (step) begin
        out_vld_q <= res_valid;
      end else if (rsp_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (step && res_valid) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid         = out_vld_q;
  assign rsp_o.response_kind = out_q.response_kind;
  assign rsp_o.close_after   = out_q.close_after;

endmodule

// ===== rtl/core/hrc_checker.sv =====
// ----------------------------------------------------------------------------
// hrc_checker
// port-level checks of the request classifier, bound to the top level
// ----------------------------------------------------------------------------
`include "http_request_classifier_macros.svh"

module hrc_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_i,
  input logic       out_valid_i,
  input logic       out_ready_i,
  input logic [2:0] response_kind_i,
  input logic       close_after_i
);

  logic in_acc;
  logic err_kind;

  assign in_acc   = in_valid_i && in_ready_i;
  assign err_kind = (response_kind_i == hrc_pkg::KIND_BAD_METHOD) ||
                    (response_kind_i == hrc_pkg::KIND_BAD_REQ) ||
                    (response_kind_i == hrc_pkg::KIND_TOO_LARGE);

  // a result only appears after a word went in through the input register
  `HRC_ASSERT(a_result_has_source, clk_i, rst_ni, $rose(out_valid_i) |-> $past(in_acc, 2))

  // error responses always close the connection
  `HRC_ASSERT(a_error_closes, clk_i, rst_ni, out_valid_i && err_kind |-> close_after_i)

  `HRC_ASSERT_HELD(a_out_valid_held, clk_i, rst_ni, out_valid_i, out_ready_i, out_valid_i)

  `HRC_ASSERT_HELD(a_out_kind_held, clk_i, rst_ni, out_valid_i, out_ready_i, response_kind_i)

endmodule

bind http_request_classifier hrc_checker u_hrc_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (req_i.valid),
  .in_ready_i      (req_i.ready),
  .out_valid_i     (rsp_o.valid),
  .out_ready_i     (rsp_o.ready),
  .response_kind_i (rsp_o.response_kind),
  .close_after_i   (rsp_o.close_after)
);

// ===== test/http_request_classifier_test.sv =====
// ----------------------------------------------------------------------------
// http_request_classifier_test
// self-checking bench for the request classifier: drives the byte channel of
// a connection, predicts every response from its own copy of the parse state
// and compares each returned word in order, with random idling on both sides
// ----------------------------------------------------------------------------
module http_request_classifier_test;
  timeunit 1ns;
  timeprecision 1ps;

  // where the parser stands within the current line
  typedef enum logic [1:0] {
    LINE_REQUEST,
    LINE_HEADER,
    LINE_VALUE,
    LINE_SKIP
  } line_kind_e;

  // progress of the terminator match
  localparam logic [1:0] TERM_NONE    = 2'd0;
  localparam logic [1:0] TERM_CR      = 2'd1;
  localparam logic [1:0] TERM_CRLF    = 2'd2;
  localparam logic [1:0] TERM_CRLFCR  = 2'd3;

  localparam logic [3:0] VERSION_DONE = 4'd9;
  localparam logic [3:0] MATCH_FAILED = 4'd15;
  localparam logic [3:0] NAME_LEN     = 4'd11;
  localparam logic [2:0] WORD_LEN     = 3'd5;

  // idle cycles with no word moving on either channel before giving up
  localparam int unsigned STALL_LIMIT = 3000;

  // words the run sends at least, counted over all tests
  localparam int unsigned ITEM_COUNT  = 1300;

  // slots for responses in flight, far more than the block can hold
  localparam int unsigned DUE_DEPTH   = 16;

  logic clk_i;
  logic rst_ni;

  hrc_req_if req ();
  hrc_rsp_if rsp ();

  http_request_classifier uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .rsp_o  (rsp)
  );

  // match strings, kept here so the prediction stands apart from the rtl
  string method_txt  = "GET ";
  string health_txt  = "/health";
  string plain_txt   = "/plaintext";
  string version_txt = " HTTP/1.1";
  string name_txt    = "connection:";
  string word_txt    = "close";

  // ---------------------------------------------------------------------------
  // predicted parse state
  // ---------------------------------------------------------------------------
  logic [hrc_pkg::PendW-1:0] held_bytes;     // bytes since the last request ended
  logic [1:0]       term_step;
  line_kind_e       line_kind;
  logic [13:0]      line_len;       // bytes seen on the request line
  logic             method_good;
  logic [1:0]       target_hits;    // bit 0 health, bit 1 plaintext
  logic [3:0]       version_step;
  logic [3:0]       name_step;
  logic [2:0]       word_step;
  logic             wants_close;
  logic             link_closed;    // connection shut, bytes dropped

  // responses worked out but not yet returned, oldest at the read slot
  hrc_pkg::result_t due_responses [DUE_DEPTH];
  logic [3:0]       due_wr = '0;    // moved on by the sender
  logic [3:0]       due_rd = '0;    // moved on by the checker

  // bench bookkeeping
  logic             open_next;      // next word starts a fresh connection
  logic             no_idle;        // both sides run flat out while set
  int unsigned      mismatch_count = 0;
  int unsigned      sent_words;
  int unsigned      idle_cycles = 0;

  // ---------------------------------------------------------------------------
  // clock and reset
  // ---------------------------------------------------------------------------
  always begin
    clk_i = 1'b0;
    #5ns;
    clk_i = 1'b1;
    #5ns;
  end

  // ---------------------------------------------------------------------------
  // prediction
  // ---------------------------------------------------------------------------
  function automatic void clear_parse();
    held_bytes   = '0;
    term_step    = TERM_NONE;
    line_kind    = LINE_REQUEST;
    line_len     = '0;
    method_good  = 1'b0;
    target_hits  = 2'b11;
    version_step = '0;
    name_step    = '0;
    word_step    = '0;
    wants_close  = 1'b0;
  endfunction

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  // request line: method, then target up to the space, then the version
  function automatic void take_request_byte(input logic [7:0] c);
    int  pos;
    int  tgt;
    logic m;
    pos = int'(line_len);
    if (pos < 4) begin
      m = (c == method_txt[pos]);
      method_good = (pos == 0) ? m : (method_good && m);
    end else if (version_step == 4'd0) begin
      tgt = pos - 4;
      if (c == hrc_pkg::CH_SPACE) begin
        // a target only counts when the space lands right after it
        target_hits  = {target_hits[1] && (tgt == 10), target_hits[0] && (tgt == 7)};
        version_step = 4'd1;
      end else begin
        if (!(tgt < 7 && c == health_txt[tgt])) target_hits[0] = 1'b0;
        if (!(tgt < 10 && c == plain_txt[tgt])) target_hits[1] = 1'b0;
      end
    end else if (version_step < VERSION_DONE) begin
      if (c == version_txt[int'(version_step)]) version_step = version_step + 4'd1;
      else version_step = MATCH_FAILED;
    end
    if (line_len != '1) line_len = line_len + 14'd1;
  endfunction

  function automatic void take_byte(input logic [7:0] c);
    logic first;
    logic matched;
    case (line_kind)
      LINE_REQUEST: take_request_byte(c);
      LINE_HEADER: begin
        if (name_step < NAME_LEN) begin
          if (to_lower(c) == name_txt[int'(name_step)]) begin
            name_step = name_step + 4'd1;
            if (name_step == NAME_LEN) begin
              line_kind = LINE_VALUE;
              word_step = '0;
            end
          end else begin
            name_step = MATCH_FAILED;
          end
        end
      end
      LINE_VALUE: begin
        if (word_step < WORD_LEN) begin
          first   = (c == "c" || c == "C");
          matched = (word_step == 3'd0) ? first : (c == word_txt[int'(word_step)]);
          if (matched) word_step = word_step + 3'd1;
          else word_step = first ? 3'd1 : 3'd0;
          if (word_step == WORD_LEN) wants_close = 1'b1;
        end
      end
      default: ;
    endcase
  endfunction

  // only the first connection header decides, later ones are skipped
  function automatic void close_line();
    if (line_kind == LINE_VALUE) line_kind = LINE_SKIP;
    else if (line_kind != LINE_SKIP) line_kind = LINE_HEADER;
    name_step = '0;
  endfunction

  function automatic void classify_byte(input logic [7:0] c, input logic fresh,
                                        output logic answered,
                                        output hrc_pkg::result_t res);
    logic after_cr;
    answered = 1'b0;
    res      = '0;
    if (fresh) begin
      clear_parse();
      link_closed = 1'b0;
    end
    if (link_closed) return;
    after_cr = (term_step == TERM_CR) || (term_step == TERM_CRLFCR);
    if (c == hrc_pkg::CH_LF && after_cr) begin
      if (term_step == TERM_CRLFCR) begin
        // blank line: the request is complete
        if (line_len < 14'd4 || !method_good) begin
          res.response_kind = hrc_pkg::KIND_BAD_METHOD;
          res.close_after   = 1'b1;
        end else if (version_step != VERSION_DONE) begin
          res.response_kind = hrc_pkg::KIND_BAD_REQ;
          res.close_after   = 1'b1;
        end else begin
          res.response_kind = target_hits[0] ? hrc_pkg::KIND_HEALTH :
                              target_hits[1] ? hrc_pkg::KIND_PLAINTEXT :
                                               hrc_pkg::KIND_NOT_FOUND;
          res.close_after   = wants_close;
        end
        clear_parse();
        link_closed = res.close_after;
        answered    = 1'b1;
        return;
      end
      close_line();
      term_step = TERM_CRLF;
    end else begin
      // a carriage return not followed by a line feed is an ordinary byte
      if (after_cr) take_byte(hrc_pkg::CH_CR);
      if (c == hrc_pkg::CH_CR) begin
        term_step = (term_step == TERM_CRLF) ? TERM_CRLFCR : TERM_CR;
      end else begin
        take_byte(c);
        term_step = TERM_NONE;
      end
    end
    held_bytes = held_bytes + 1'b1;
    if (held_bytes >= hrc_pkg::BUFFER_BYTES) begin
      link_closed       = 1'b1;
      answered          = 1'b1;
      res.response_kind = hrc_pkg::KIND_TOO_LARGE;
      res.close_after   = 1'b1;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // idling: mostly short gaps, now and then a long one
  // ---------------------------------------------------------------------------
  function automatic int unsigned draw_gap();
    int unsigned r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // result side back-pressure
  initial begin
    int unsigned stall;
    rsp.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      stall = draw_gap();
      if (stall != 0) begin
        rsp.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      rsp.ready <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // result checking
  // ---------------------------------------------------------------------------
  task automatic note_mismatch(input string what, input hrc_pkg::result_t want,
                               input hrc_pkg::result_t got);
    mismatch_count++;
    if (mismatch_count <= 10)
      $display("mismatch, %s: expected kind %0d close %0d, got kind %0d close %0d",
               what, want.response_kind, want.close_after,
               got.response_kind, got.close_after);
  endtask

  always @(posedge clk_i) begin
    hrc_pkg::result_t got;
    hrc_pkg::result_t want;
    if (rst_ni && rsp.valid && rsp.ready) begin
      got.response_kind = rsp.response_kind;
      got.close_after   = rsp.close_after;
      if (due_wr == due_rd) begin
        note_mismatch("no response due", '0, got);
      end else begin
        want   = due_responses[due_rd];
        due_rd <= due_rd + 4'd1;
        if (got.response_kind !== want.response_kind || got.close_after !== want.close_after)
          note_mismatch("wrong response", want, got);
      end
    end
  end

  // watchdog: no word moving on either side for too long means a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles + 1 >= STALL_LIMIT) begin
        $display("tb: failure");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------

  // one byte word; the prediction runs once the word has been taken
  task automatic send_byte(input logic [7:0] c);
    int unsigned      gap;
    logic             answered;
    hrc_pkg::result_t res;
    gap = draw_gap();
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid          <= 1'b1;
    req.data_byte      <= c;
    req.new_connection <= open_next;
    @(posedge clk_i);
    while (!req.ready) @(posedge clk_i);
    classify_byte(c, open_next, answered, res);
    open_next = 1'b0;
    if (answered) begin
      due_responses[due_wr] = res;
      due_wr                = due_wr + 4'd1;
    end
    sent_words++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_line(input string s);
    send_text(s);
    send_byte(hrc_pkg::CH_CR);
    send_byte(hrc_pkg::CH_LF);
  endtask

  // letters flipped to upper case at random
  task automatic send_mixed_case(input string s);
    logic [7:0] c;
    for (int i = 0; i < s.len(); i++) begin
      c = s[i];
      if (c >= "a" && c <= "z" && $urandom_range(0, 1) == 1) c = c - 8'd32;
      send_byte(c);
    end
  endtask

  // the sender holds off until every due response has come back
  task automatic wait_answers_drained();
    req.valid <= 1'b0;
    @(posedge clk_i);
    while (due_wr != due_rd) @(posedge clk_i);
  endtask

  task automatic send_random_request();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    // method, mostly right
    if (pick < 85) begin
      send_text("GET ");
    end else begin
      case (pick % 4)
        0:       send_text("POST ");
        1:       send_text("GEt ");
        2:       send_text("GE");
        default: repeat ($urandom_range(0, 5)) send_byte(8'($urandom_range(0, 255)));
      endcase
    end
    // target, near misses included
    case ($urandom_range(0, 9))
      0, 1, 2: send_text("/health");
      3, 4, 5: send_text("/plaintext");
      6:       send_text("/");
      7:       send_text("/healthz");
      8:       send_text("/plain");
      default: begin
        send_byte("/");
        repeat ($urandom_range(0, 8)) send_byte(8'($urandom_range(33, 126)));
      end
    endcase
    // version
    pick = $urandom_range(0, 99);
    if (pick < 85) begin
      send_text(" HTTP/1.1");
    end else begin
      case (pick % 5)
        0:       send_text(" HTTP/1.0");
        1:       ;
        2:       send_text(" HTTP/1.1 x");
        3:       send_text("  HTTP/1.1");
        default: send_text(" http/1.1");
      endcase
    end
    // stray carriage return at the end of the request line
    if ($urandom_range(0, 9) == 0) send_byte(hrc_pkg::CH_CR);
    send_byte(hrc_pkg::CH_CR);
    send_byte(hrc_pkg::CH_LF);
    // headers
    repeat ($urandom_range(0, 3)) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) begin
        send_mixed_case("connection:");
        case ($urandom_range(0, 8))
          0:       send_text(" close");
          1:       send_text(" Close");
          2:       send_text(" keep-alive");
          3:       send_text("close");
          4:       send_text(" cLose");
          5:       send_text(" x, ccclose");
          6:       send_text(" clos");
          7:       send_text(" CLOSE");
          default: send_text(" upgrade, close");
        endcase
      end else if (pick < 55) begin
        send_mixed_case("connectio: close");
      end else begin
        send_text("X-");
        repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(33, 126)));
        send_text(": ");
        repeat ($urandom_range(0, 10))
          send_byte(8'(($urandom_range(0, 19) == 0) ? $urandom_range(0, 255)
                                                    : $urandom_range(32, 126)));
      end
      send_byte(hrc_pkg::CH_CR);
      send_byte(hrc_pkg::CH_LF);
    end
    // now and then the request is cut short
    if ($urandom_range(0, 9) != 0) begin
      send_byte(hrc_pkg::CH_CR);
      send_byte(hrc_pkg::CH_LF);
    end
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // both served targets and an unknown one on a kept-alive connection
  task automatic test_served_targets();
    open_next = 1'b1;
    send_line("GET /health HTTP/1.1");
    send_line("");
    send_line("GET /plaintext HTTP/1.1");
    send_line("Host: a");
    send_line("");
    send_line("GET /other HTTP/1.1");
    send_line("");
  endtask

  // wrong method, short request line, bad or missing version
  task automatic test_request_errors();
    open_next = 1'b1;
    send_line("POST / HTTP/1.1");
    send_line("");
    open_next = 1'b1;
    send_line("GE");
    send_line("");
    open_next = 1'b1;
    send_line("");
    send_line("");
    open_next = 1'b1;
    send_line("GET /health HTTP/1.0");
    send_line("");
    open_next = 1'b1;
    send_line("GET /health");
    send_line("");
  endtask

  // close handling, bytes dropped after close, first connection header wins
  task automatic test_connection_close();
    open_next = 1'b1;
    send_line("GET /plaintext HTTP/1.1");
    send_line("Connection: close");
    send_line("");
    send_line("GET /health HTTP/1.1");
    send_line("");
    open_next = 1'b1;
    send_line("GET /nope HTTP/1.1");
    send_line("CONNECTION: keep-alive, Close");
    send_line("");
    open_next = 1'b1;
    send_line("GET /health HTTP/1.1");
    send_line("Connection: keep-alive");
    send_line("Connection: close");
    send_line("");
    send_line("GET /health HTTP/1.1");
    send_line("connection: ccloseX");
    send_line("");
  endtask

  // lone carriage returns, extreme byte values, a restart mid-request
  task automatic test_odd_bytes();
    open_next = 1'b1;
    send_text("GET /he");
    send_byte(hrc_pkg::CH_CR);
    send_line("alth HTTP/1.1");
    send_text("X-");
    send_byte(8'h00);
    send_byte(8'hff);
    send_byte(8'h80);
    send_text(": v");
    send_byte(hrc_pkg::CH_CR);
    send_line("");
    send_line("");
    open_next = 1'b1;
    send_text("GET /heal");
    open_next = 1'b1;
    send_line("GET /health HTTP/1.1");
    send_line("");
  endtask

  // mostly well-formed requests with random content, some noise and restarts,
  // until the run has sent its share of words
  task automatic test_random_traffic();
    while (sent_words < ITEM_COUNT) begin
      if (link_closed || $urandom_range(0, 19) == 0) begin
        // a few dropped bytes before the reopen now and then
        if (link_closed && $urandom_range(0, 4) == 0)
          repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
        open_next = 1'b1;
      end
      if ($urandom_range(0, 99) < 8)
        repeat ($urandom_range(1, 20)) send_byte(8'($urandom_range(0, 255)));
      else send_random_request();
      if ($urandom_range(0, 6) == 0) no_idle = !no_idle;
      if ($urandom_range(0, 24) == 0) wait_answers_drained();
    end
    no_idle = 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_ni             = 1'b0;
    req.valid          = 1'b0;
    req.data_byte      = '0;
    req.new_connection = 1'b0;
    open_next          = 1'b0;
    no_idle            = 1'b0;
    sent_words         = 0;
    clear_parse();
    link_closed        = 1'b0;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    test_served_targets();
    test_request_errors();
    wait_answers_drained();
    test_connection_close();
    test_odd_bytes();
    wait_answers_drained();
    test_random_traffic();

    // let the last responses out and give the block time to settle
    wait_answers_drained();
    repeat (8) @(posedge clk_i);

    if (mismatch_count == 0 && due_wr == due_rd) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/hrc_pkg.sv
rtl/core/hrc_if.sv
rtl/core/hrc_parser.sv
rtl/core/http_request_classifier.sv
rtl/core/hrc_checker.sv
test/http_request_classifier_test.sv
